// File: rtl/core/sal_pkg.sv
// Shared constants, codes and types of the settings append log.
package sal_pkg;

    // Page geometry
    localparam int LOG_SLOTS = 256;
    localparam int SLOT_W    = $clog2(LOG_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int WORD_W    = 32;

    // Field widths fixed by the port list
    localparam int BRIGHT_W  = 8;
    localparam int ANIM_W    = 16;
    localparam int NEXT_W    = 9;
    localparam int REC_W     = 8;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_SET_BRIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_ANIM   = 2'd1;
    localparam logic [OP_W-1:0] OP_STORE      = 2'd2;
    localparam logic [OP_W-1:0] OP_LOAD       = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIMATION  = 2'd1;

    // Record id bytes and whole words
    localparam logic [7:0]        ID_SET      = 8'h00;
    localparam logic [7:0]        ID_MARK     = 8'hAA;
    localparam logic [WORD_W-1:0] SLOT_EMPTY  = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] MARKER_WORD = 32'h0000_00AA;

    // Reset values of the current settings
    localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS = 8'd100;
    localparam logic [ANIM_W-1:0]   RST_ANIMATION  = 16'd0;

    // Access request from the controller to the log memory
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              erase;
    } ram_req_t;

    // Finished result from the controller to the output stage
    typedef struct packed {
        logic                valid;
        logic [BRIGHT_W-1:0] brightness;
        logic [ANIM_W-1:0]   animation;
        logic [NEXT_W-1:0]   next_slot;
        logic                erased;
        logic                written;
        logic [REC_W-1:0]    rslot;
    } result_t;

endpackage

// File: rtl/core/sal_log_ram.sv
// Log page memory: one write port, one registered read port, erase of the whole page at once.
module sal_log_ram (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sal_pkg::ram_req_t              req,
    output logic [sal_pkg::WORD_W-1:0]     rd_data
);
    import sal_pkg::*;

    logic [WORD_W-1:0]    log_mem [LOG_SLOTS];
    logic [LOG_SLOTS-1:0] slot_valid_reg;
    logic [LOG_SLOTS-1:0] slot_valid_next;
    logic [WORD_W-1:0]    rd_word_reg;
    logic                 rd_valid_reg;

    // Payload array: no reset, erased slots are masked by the valid bits
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            log_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_word_reg <= log_mem[req.rd_addr];
        end
    end

    // Erase drops every slot; a write in the same cycle survives it
    always_comb begin
        slot_valid_next = slot_valid_reg;
        if (req.erase) begin
            slot_valid_next = '0;
        end
        if (req.wr_en) begin
            slot_valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end else begin
            slot_valid_reg <= slot_valid_next;
            if (req.rd_en) begin
                rd_valid_reg <= slot_valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : SLOT_EMPTY;

endmodule

// File: rtl/core/sal_ctrl.sv
// Sequencer for set, store and load requests, holding the current settings.
module sal_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sal_pkg::OP_W-1:0]          s_opcode,
    input  logic [sal_pkg::BRIGHT_W-1:0]      s_new_brightness,
    input  logic [sal_pkg::ANIM_W-1:0]        s_new_animation,
    input  logic                              cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sal_pkg::CFG_DAT_W-1:0]     cfg_data,
    output sal_pkg::ram_req_t                 ram_req,
    input  logic [sal_pkg::WORD_W-1:0]        rd_data,
    output sal_pkg::result_t                  res,
    input  logic                              res_ready
);
    import sal_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MARK   = 3'd1;
    localparam logic [2:0] ST_APPEND = 3'd2;
    localparam logic [2:0] ST_LOAD   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]          state_reg,       state_next;
    logic [BRIGHT_W-1:0] cur_bright_reg,  cur_bright_next;
    logic [ANIM_W-1:0]   cur_anim_reg,    cur_anim_next;
    logic [CNT_W-1:0]    write_slot_reg,  write_slot_next;
    logic [CNT_W-1:0]    scan_reg,        scan_next;
    logic                erased_reg,      erased_next;
    logic                written_reg,     written_next;
    logic [REC_W-1:0]    rslot_reg,       rslot_next;
    logic                accept;
    logic                need_erase;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign need_erase = (rd_data[7:0] != ID_MARK)
                     || (write_slot_reg >= CNT_W'(LOG_SLOTS))
                     || (write_slot_reg == '0);

    always_comb begin
        state_next      = state_reg;
        cur_bright_next = cur_bright_reg;
        cur_anim_next   = cur_anim_reg;
        write_slot_next = write_slot_reg;
        scan_next       = scan_reg;
        erased_next     = erased_reg;
        written_next    = written_reg;
        rslot_next      = rslot_reg;
        ram_req         = '0;

        // Register writes also replace the current value
        if (cfg_we) begin
            case (cfg_index)
                CFG_BRIGHTNESS: cur_bright_next = cfg_data[BRIGHT_W-1:0];
                CFG_ANIMATION:  cur_anim_next   = cfg_data[ANIM_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    erased_next  = 1'b0;
                    written_next = 1'b0;
                    rslot_next   = '0;
                    case (s_opcode)
                        OP_SET_BRIGHT: begin
                            cur_bright_next = s_new_brightness;
                            state_next      = ST_RESULT;
                        end
                        OP_SET_ANIM: begin
                            cur_anim_next = s_new_animation;
                            state_next    = ST_RESULT;
                        end
                        OP_STORE: begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = '0;
                            state_next      = ST_MARK;
                        end
                        default: begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = SLOT_W'(1);
                            scan_next       = CNT_W'(1);
                            state_next      = ST_LOAD;
                        end
                    endcase
                end
            end
            ST_MARK: begin
                // Missing marker or full page: erase, rewrite marker, restart
                if (need_erase) begin
                    ram_req.erase   = 1'b1;
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = '0;
                    ram_req.wr_data = MARKER_WORD;
                    write_slot_next = CNT_W'(1);
                    erased_next     = 1'b1;
                end
                state_next = ST_APPEND;
            end
            ST_APPEND: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = write_slot_reg[SLOT_W-1:0];
                ram_req.wr_data = {cur_bright_reg, cur_anim_reg, ID_SET};
                written_next    = 1'b1;
                rslot_next      = REC_W'(write_slot_reg);
                write_slot_next = write_slot_reg + CNT_W'(1);
                state_next      = ST_RESULT;
            end
            ST_LOAD: begin
                if (rd_data[7:0] == ID_SET) begin
                    cur_anim_next   = rd_data[23:8];
                    cur_bright_next = rd_data[31:24];
                    if (scan_reg == CNT_W'(LOG_SLOTS - 1)) begin
                        write_slot_next = CNT_W'(LOG_SLOTS);
                        state_next      = ST_RESULT;
                    end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = SLOT_W'(scan_reg + CNT_W'(1));
                        scan_next       = scan_reg + CNT_W'(1);
                    end
                end else begin
                    write_slot_next = scan_reg;
                    state_next      = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_bright_reg <= RST_BRIGHTNESS;
            cur_anim_reg   <= RST_ANIMATION;
            write_slot_reg <= CNT_W'(1);
        end else begin
            state_reg      <= state_next;
            cur_bright_reg <= cur_bright_next;
            cur_anim_reg   <= cur_anim_next;
            write_slot_reg <= write_slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg    <= scan_next;
        erased_reg  <= erased_next;
        written_reg <= written_next;
        rslot_reg   <= rslot_next;
    end

    assign res.valid      = (state_reg == ST_RESULT);
    assign res.brightness = cur_bright_reg;
    assign res.animation  = cur_anim_reg;
    assign res.next_slot  = NEXT_W'(write_slot_reg);
    assign res.erased     = erased_reg;
    assign res.written    = written_reg;
    assign res.rslot      = rslot_reg;

endmodule

// File: rtl/core/settings_append_log.sv
// Top level of the settings append log: controller, log memory and output register.
//
// Usage:
//   Requests enter on the s_ channel (valid/ready): an opcode plus a new
//   brightness and a new animation id. Opcode 0 sets the brightness, 1 sets
//   the animation id, 2 appends the current settings to the log page, and
//   3 reloads the newest settings from the page. Every request returns one
//   result on the m_ channel: current settings, next log slot, and flags
//   for page erase and record append with the slot that was written.
//   The cfg_ channel writes the brightness (index 0) or animation
//   (index 1); the value replaces the current setting at once.
//   cfg_ready is always high. Write configuration only while idle.
// Sequencing:
//   One request is in work at a time. A set request goes straight to the
//   result, a store passes marker read, optional erase and append, and a
//   load reads records from slot 1 up to the first slot without one or
//   the last slot, through the single read port of the log memory, which
//   it scans one slot per cycle.
// Reset:
//   Synchronous, active low. The page reads as erased right after reset
//   (per-slot valid bits), brightness returns to 100, animation to 0, and
//   the next slot to 1. No clearing pass is needed.
// Stalls:
//   A result held by a low m_ready stays in the output register while the
//   next request is accepted and worked on; that one waits for the register.
module settings_append_log (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sal_pkg::OP_W-1:0]          s_opcode,
    input  logic [sal_pkg::BRIGHT_W-1:0]      s_new_brightness,
    input  logic [sal_pkg::ANIM_W-1:0]        s_new_animation,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sal_pkg::BRIGHT_W-1:0]      m_brightness_now,
    output logic [sal_pkg::ANIM_W-1:0]        m_animation_now,
    output logic [sal_pkg::NEXT_W-1:0]        m_next_slot,
    output logic                              m_page_erased,
    output logic                              m_record_written,
    output logic [sal_pkg::REC_W-1:0]         m_record_slot,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sal_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sal_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import sal_pkg::*;

    ram_req_t          ram_req;
    logic [WORD_W-1:0] rd_data;
    result_t           res;
    logic              res_ready;
    logic              res_take;

    logic                m_valid_reg,  m_valid_next;
    logic [BRIGHT_W-1:0] m_bright_reg;
    logic [ANIM_W-1:0]   m_anim_reg;
    logic [NEXT_W-1:0]   m_next_reg;
    logic                m_erased_reg;
    logic                m_written_reg;
    logic [REC_W-1:0]    m_rslot_reg;

    // Configuration writes are taken in any cycle
    assign cfg_ready = 1'b1;

    sal_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_new_brightness (s_new_brightness),
        .s_new_animation  (s_new_animation),
        .cfg_we           (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .ram_req          (ram_req),
        .rd_data          (rd_data),
        .res              (res),
        .res_ready        (res_ready)
    );

    sal_log_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // Output register: refill when empty or when the held result leaves
    assign res_ready = !m_valid_reg || m_ready;
    assign res_take  = res.valid && res_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_take) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the payload until the next result is taken
    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_bright_reg  <= res.brightness;
            m_anim_reg    <= res.animation;
            m_next_reg    <= res.next_slot;
            m_erased_reg  <= res.erased;
            m_written_reg <= res.written;
            m_rslot_reg   <= res.rslot;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_brightness_now = m_bright_reg;
    assign m_animation_now  = m_anim_reg;
    assign m_next_slot      = m_next_reg;
    assign m_page_erased    = m_erased_reg;
    assign m_record_written = m_written_reg;
    assign m_record_slot    = m_rslot_reg;

endmodule

// File: rtl/core/sal_checker.sv
// Port-level checks of the settings append log, bound to the top level.
module sal_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [sal_pkg::NEXT_W-1:0]        m_next_slot,
    input  logic                              m_page_erased,
    input  logic                              m_record_written,
    input  logic [sal_pkg::REC_W-1:0]         m_record_slot
);
    import sal_pkg::*;

    // A stalled result stays valid with its next slot and record slot held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_slot)
                                && $stable(m_record_slot))
        else $error("stalled result changed");

    // An append advances the next slot past the written one
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_record_written
            |-> m_next_slot == NEXT_W'(m_record_slot) + NEXT_W'(1))
        else $error("next slot does not follow appended slot");

    // A result without an append reports slot zero
    a_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_record_written |-> m_record_slot == '0)
        else $error("record slot set without append");

    // An erase is only done by a store, which then writes slot one
    a_erase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_page_erased |-> m_record_written && m_record_slot == REC_W'(1))
        else $error("erase without append at slot one");

endmodule

bind settings_append_log sal_checker u_sal_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_next_slot      (m_next_slot),
    .m_page_erased    (m_page_erased),
    .m_record_written (m_record_written),
    .m_record_slot    (m_record_slot)
);
